// ----- rtl/core/jmb_pkg.sv -----
// Shared types and constants for the joystick to MIDI event bridge.
// Holds the payload structs, the job descriptor and the message codes.
// No dependencies.
`timescale 1ns / 1ps

package jmb_pkg;

  localparam int BTN_W           = 12;
  localparam int NUM_BUTTONS_DEF = 12;
  localparam int AXIS_SLOTS      = 4;
  localparam int PEND_W          = AXIS_SLOTS + BTN_W;
  localparam int SEL_W           = $clog2(PEND_W);

  localparam logic [1:0] KIND_PITCH = 2'd0;
  localparam logic [1:0] KIND_CC    = 2'd1;
  localparam logic [1:0] KIND_ON    = 2'd2;
  localparam logic [1:0] KIND_OFF   = 2'd3;

  localparam logic [6:0] CC_MOD    = 7'd1;
  localparam logic [6:0] CC_CUTOFF = 7'd74;
  localparam logic [6:0] CC_VOLUME = 7'd7;

  localparam logic [1:0] REG_MIDI_CHANNEL  = 2'd0;
  localparam logic [1:0] REG_BASE_NOTE     = 2'd1;
  localparam logic [1:0] REG_NOTE_VELOCITY = 2'd2;

  localparam logic [3:0] RST_MIDI_CHANNEL  = 4'd0;
  localparam logic [6:0] RST_BASE_NOTE     = 7'd60;
  localparam logic [6:0] RST_NOTE_VELOCITY = 7'd100;

  // Slots of the pending mask, in emission order.
  localparam logic [SEL_W-1:0] SLOT_PITCH  = SEL_W'(0);
  localparam logic [SEL_W-1:0] SLOT_MOD    = SEL_W'(1);
  localparam logic [SEL_W-1:0] SLOT_CUTOFF = SEL_W'(2);
  localparam logic [SEL_W-1:0] SLOT_VOLUME = SEL_W'(3);

  typedef struct packed {
    logic [13:0] axis_x;
    logic [13:0] axis_y;
    logic [7:0]  twist_pos;
    logic [7:0]  fader_pos;
    logic [11:0] button_bits;
    logic        sink_ready;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  msg_kind;
    logic [3:0]  channel_out;
    logic [6:0]  first_data;
    logic [13:0] value_data;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0] midi_channel;
    logic [6:0] base_note;
    logic [6:0] note_velocity;
  } cfg_regs_t;

  // One report's worth of work: which messages to send and their values.
  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic [13:0]       pitch;
    logic [6:0]        mod;
    logic [6:0]        cutoff;
    logic [6:0]        volume;
    logic [BTN_W-1:0]  buttons;
  } job_t;

endpackage

// ----- rtl/core/jmb_front.sv -----
// Front end: accepts reports, compares them with the sent values and builds jobs.
// Depends on jmb_pkg.
`timescale 1ns / 1ps

module jmb_front #(
  parameter int NUM_BUTTONS = jmb_pkg::NUM_BUTTONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  jmb_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output jmb_pkg::job_t    q_wdata
);
  import jmb_pkg::*;

  localparam int NB_CMP = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

  logic [13:0]      sent_pitch_r,   sent_pitch_nxt;
  logic [6:0]       sent_mod_r,     sent_mod_nxt;
  logic [6:0]       sent_cutoff_r,  sent_cutoff_nxt;
  logic [7:0]       seen_fader_r,   seen_fader_nxt;
  logic [BTN_W-1:0] seen_buttons_r, seen_buttons_nxt;

  logic             accept;
  logic             rdy;
  logic [13:0]      mod_diff;
  logic [7:0]       mod_raw;
  logic [6:0]       mod_val;
  logic [6:0]       cutoff_val;
  logic [BTN_W-1:0] cmp_mask;
  logic [BTN_W-1:0] btn_chg;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign rdy      = in_data.sink_ready;

  always_comb begin
    for (int i = 0; i < BTN_W; i++) begin
      cmp_mask[i] = (i < NB_CMP);
    end
  end

  // Forward travel only: axis_y below centre has its top bit clear.
  assign mod_diff   = 14'd8192 - in_data.axis_y;
  assign mod_raw    = mod_diff[13:6];
  assign mod_val    = in_data.axis_y[13] ? 7'd0 :
                      (mod_raw[7] ? 7'd127 : mod_raw[6:0]);
  assign cutoff_val = in_data.twist_pos[7:1];
  assign btn_chg    = (in_data.button_bits ^ seen_buttons_r) & cmp_mask;

  always_comb begin
    q_wdata         = '0;
    q_wdata.pitch   = in_data.axis_x;
    q_wdata.mod     = mod_val;
    q_wdata.cutoff  = cutoff_val;
    q_wdata.volume  = 7'd127 - in_data.fader_pos[7:1];
    q_wdata.buttons = in_data.button_bits;
    if (rdy) begin
      q_wdata.pend[SLOT_PITCH]  = (in_data.axis_x != sent_pitch_r);
      q_wdata.pend[SLOT_MOD]    = (mod_val != sent_mod_r);
      q_wdata.pend[SLOT_CUTOFF] = (cutoff_val != sent_cutoff_r);
      q_wdata.pend[SLOT_VOLUME] = (in_data.fader_pos != seen_fader_r);
      q_wdata.pend[PEND_W-1:AXIS_SLOTS] = btn_chg;
    end
  end

  assign q_push = accept && (q_wdata.pend != '0);

  always_comb begin
    sent_pitch_nxt   = sent_pitch_r;
    sent_mod_nxt     = sent_mod_r;
    sent_cutoff_nxt  = sent_cutoff_r;
    seen_fader_nxt   = seen_fader_r;
    seen_buttons_nxt = seen_buttons_r;
    if (accept) begin
      if (rdy) begin
        sent_pitch_nxt  = in_data.axis_x;
        sent_mod_nxt    = mod_val;
        sent_cutoff_nxt = cutoff_val;
      end
      seen_fader_nxt   = in_data.fader_pos;
      seen_buttons_nxt = in_data.button_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_pitch_r   <= '0;
      sent_mod_r     <= '0;
      sent_cutoff_r  <= '0;
      seen_fader_r   <= '0;
      seen_buttons_r <= '0;
    end else begin
      sent_pitch_r   <= sent_pitch_nxt;
      sent_mod_r     <= sent_mod_nxt;
      sent_cutoff_r  <= sent_cutoff_nxt;
      seen_fader_r   <= seen_fader_nxt;
      seen_buttons_r <= seen_buttons_nxt;
    end
  end

endmodule

// ----- rtl/core/jmb_queue.sv -----
// Two-entry job queue between the front end and the message sequencer.
// Depends on jmb_pkg.
`timescale 1ns / 1ps

module jmb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jmb_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output jmb_pkg::job_t rdata
);
  import jmb_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/jmb_back.sv -----
// Message sequencer: walks a job's pending mask, one message per cycle if unstalled.
// Depends on jmb_pkg.
`timescale 1ns / 1ps

module jmb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jmb_pkg::cfg_regs_t cfg,
  input  logic               q_valid,
  input  jmb_pkg::job_t      q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output jmb_pkg::out_item_t out_data
);
  import jmb_pkg::*;

  job_t              work_r,       work_nxt;
  logic              work_valid_r, work_valid_nxt;
  logic              out_valid_r,  out_valid_nxt;
  out_item_t         out_data_r,   out_data_nxt;

  logic              slot_free;
  logic              emit;
  logic              last;
  logic [PEND_W-1:0] pend_rest;
  logic [SEL_W-1:0]  sel;
  logic [3:0]        btn_idx;
  out_item_t         msg;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = work_valid_r && slot_free;
  assign pend_rest = work_r.pend & (work_r.pend - PEND_W'(1));
  assign last      = (pend_rest == '0);
  assign q_pop     = q_valid && (!work_valid_r || (emit && last));

  // Lowest pending slot goes first.
  always_comb begin
    sel = '0;
    for (int i = PEND_W - 1; i >= 0; i--) begin
      if (work_r.pend[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign btn_idx = 4'(sel - SEL_W'(AXIS_SLOTS));

  always_comb begin
    msg             = '0;
    msg.channel_out = cfg.midi_channel;
    msg.last_of_run = last;
    case (sel)
      SLOT_PITCH: begin
        msg.msg_kind   = KIND_PITCH;
        msg.value_data = work_r.pitch;
      end
      SLOT_MOD: begin
        msg.msg_kind   = KIND_CC;
        msg.first_data = CC_MOD;
        msg.value_data = {7'd0, work_r.mod};
      end
      SLOT_CUTOFF: begin
        msg.msg_kind   = KIND_CC;
        msg.first_data = CC_CUTOFF;
        msg.value_data = {7'd0, work_r.cutoff};
      end
      SLOT_VOLUME: begin
        msg.msg_kind   = KIND_CC;
        msg.first_data = CC_VOLUME;
        msg.value_data = {7'd0, work_r.volume};
      end
      default: begin
        msg.msg_kind   = work_r.buttons[btn_idx] ? KIND_ON : KIND_OFF;
        msg.first_data = cfg.base_note + {3'd0, btn_idx};
        msg.value_data = {7'd0, cfg.note_velocity};
      end
    endcase
  end

  always_comb begin
    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (emit) begin
      work_nxt.pend = pend_rest;
      out_data_nxt  = msg;
      out_valid_nxt = 1'b1;
      if (last) begin
        work_valid_nxt = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      work_nxt       = q_rdata;
      work_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/joystick_to_midi_event_bridge.sv -----
// Top level of the joystick to MIDI event bridge: configuration registers and wiring.
// Depends on jmb_pkg, jmb_front, jmb_queue and jmb_back.
//
// A joystick report is offered on the in_ channel (in_valid, in_data) and is taken at a
// clock edge where in_valid is high and in_stall is low. Each report turns into zero to
// sixteen MIDI message requests on the out_ channel, in the order pitch wheel, mod
// wheel, cutoff, volume, then one note on or off per changed button, lowest first. The
// final request of a report carries last_of_run. A report that changes nothing, or one
// seen while sink_ready is low, produces no requests, though its fader and button values
// are still recorded.
// The first request of a report passes through the job queue, the work register of jmb_back
// and its output register before it reaches out_valid. The sequencer emits one request per
// cycle while out_stall is low, at most sixteen per report. The front end accepts a report
// every cycle while the two-entry job queue has room; in_stall is high only while it is full.
// Configuration: cfg_ready is always high; midi_channel, base_note and note_velocity sit at
// indexes 0 to 2 and should be written only while idle. Reset (rst_n low, synchronous)
// clears the saved values, empties the queue and output register, and loads channel 0, base
// note 60 and velocity 100. When the receiver raises out_stall, the held request stays
// unchanged; the queue keeps absorbing reports until it fills, and then in_stall rises.
`timescale 1ns / 1ps

module joystick_to_midi_event_bridge #(
  parameter int NUM_BUTTONS = jmb_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jmb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jmb_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);
  import jmb_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  job_t      q_wdata;
  job_t      q_rdata;

  // The register file never back-pressures a write.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIDI_CHANNEL:  cfg_nxt.midi_channel  = cfg_wdata[3:0];
        REG_BASE_NOTE:     cfg_nxt.base_note     = cfg_wdata;
        REG_NOTE_VELOCITY: cfg_nxt.note_velocity = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.midi_channel  <= RST_MIDI_CHANNEL;
      cfg_r.base_note     <= RST_BASE_NOTE;
      cfg_r.note_velocity <= RST_NOTE_VELOCITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: change detection and the recorded values.
  jmb_front #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Decoupling queue so reports keep flowing while messages drain.
  jmb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rdata    (q_rdata)
  );

  // Back end: serializes each job into MIDI message requests.
  jmb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
